// ===== rtl/sorted_insert_and_merge_macros.svh =====
// Assertion macros shared by the sorted insert and merge RTL.
`ifndef SORTED_INSERT_AND_MERGE_MACROS_SVH
`define SORTED_INSERT_AND_MERGE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SIM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SIM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SIM_ASSERT_NOW(lbl, ante, cons, msg)
`define SIM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sim_pkg.sv =====
// Types and constants of the sorted insert and merge block.
`timescale 1ns / 1ps

package sim_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_MERGE  = 1'b1
    } t_func;

    typedef enum logic {
        SEL_A = 1'b0,
        SEL_B = 1'b1
    } t_list_sel;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MERGED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        CMP_INSERT = 1'b0,
        CMP_MERGE  = 1'b1
    } t_cmp_mode;

endpackage

// ===== rtl/sim_ifs.sv =====
// Request and result channel interfaces of the sorted insert and merge block.
`timescale 1ns / 1ps

interface sim_req_if import sim_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic                      list_select;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output func, output list_select, output value,
                     input ready);
    modport sink   (input valid, input func, input list_select, input value,
                     output ready);
endinterface

interface sim_res_if import sim_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] merged_value;
    t_status                   status;
    logic                      last;

    modport source (output valid, output merged_value, output status, output last,
                     input ready);
    modport sink   (input valid, input merged_value, input status, input last,
                     output ready);
endinterface

// ===== rtl/sim_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module sim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/sim_cmp.sv =====
// Shared signed less-than unit with operand selection for insert and merge.
`timescale 1ns / 1ps

module sim_cmp
    import sim_pkg::*;
(
    input  t_cmp_mode          i_mode,
    input  logic               i_sel,
    input  logic [VALUE_W-1:0] i_a_head,
    input  logic [VALUE_W-1:0] i_b_head,
    input  logic [VALUE_W-1:0] i_key,
    output logic [VALUE_W-1:0] o_ins_entry,
    output logic               o_lt
);

    logic [VALUE_W-1:0] lhs;
    logic [VALUE_W-1:0] rhs;

    // insert: entry of the target store vs. new value; merge: head A vs. head B
    assign o_ins_entry = (i_sel == SEL_B) ? i_b_head : i_a_head;

    always_comb begin
        case (i_mode)
            CMP_MERGE: begin
                lhs = i_a_head;
                rhs = i_b_head;
            end
            default: begin
                lhs = o_ins_entry;
                rhs = i_key;
            end
        endcase
    end

    assign o_lt = $signed(lhs) < $signed(rhs);

endmodule

// ===== rtl/sorted_insert_and_merge.sv =====
// Sorted insert and merge block: two ascending stores kept in RAM, one shared comparator.
// An insert request walks the target store from its tail down, moving every entry that
// is not below the new value up one place, one entry per cycle, then writes the value;
// a request to a full store is answered with a full status. A merge request emits each
// result as a registered read of both store heads, then a compare and output load that
// waits while the output register is busy, and clears both stores at the end; with both
// stores empty it is answered with an empty status. Each store has a single read port
// with a registered read. A finished result sits in an output register, so the next
// request is taken while it waits; a new result is held back until the register is
// free. The stores need no clearing pass after reset.
`timescale 1ns / 1ps
`include "sorted_insert_and_merge_macros.svh"

module sorted_insert_and_merge
    import sim_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sim_req_if.sink   i_req,
    sim_res_if.source o_res
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_MRG_RD,
        S_MRG_SEL,
        S_RESP
    } t_state;

    t_state             r_state,       n_state;
    logic               r_sel,         n_sel;
    logic [VALUE_W-1:0] r_value,       n_value;
    logic [CW-1:0]      r_idx,         n_idx;
    logic [CW-1:0]      r_cnt_a,       n_cnt_a;
    logic [CW-1:0]      r_cnt_b,       n_cnt_b;
    logic [CW-1:0]      r_ia,          n_ia;
    logic [CW-1:0]      r_ib,          n_ib;
    t_status            r_resp_status, n_resp_status;
    logic               r_out_valid,   n_out_valid;
    logic [VALUE_W-1:0] r_out_value,   n_out_value;
    t_status            r_out_status,  n_out_status;
    logic               r_out_last,    n_out_last;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic [VALUE_W-1:0] rd_a;
    logic [VALUE_W-1:0] rd_b;
    logic [VALUE_W-1:0] ins_entry;
    logic               cmp_lt;
    t_cmp_mode          cmp_mode;

    logic [CW-1:0]      req_cnt;
    logic [CW-1:0]      req_cnt_m1;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      idx_m2;
    logic [CW-1:0]      ia_inc;
    logic [CW-1:0]      ib_inc;
    logic               take_a;
    logic               slot_free;
    logic               mrg_load;
    logic               mrg_last;

    sim_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we && (r_sel == SEL_A)),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    sim_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we && (r_sel == SEL_B)),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    assign cmp_mode = (r_state == S_MRG_SEL) ? CMP_MERGE : CMP_INSERT;

    sim_cmp u_cmp (
        .i_mode      (cmp_mode),
        .i_sel       (r_sel),
        .i_a_head    (rd_a),
        .i_b_head    (rd_b),
        .i_key       (r_value),
        .o_ins_entry (ins_entry),
        .o_lt        (cmp_lt)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.merged_value = r_out_value;
    assign o_res.status       = r_out_status;
    assign o_res.last         = r_out_last;

    assign slot_free  = !r_out_valid || o_res.ready;
    assign req_cnt    = (i_req.list_select == SEL_B) ? r_cnt_b : r_cnt_a;
    assign req_cnt_m1 = req_cnt - ONE_C;
    assign idx_m1     = r_idx - ONE_C;
    assign idx_m2     = r_idx - TWO_C;
    assign ia_inc     = r_ia + ONE_C;
    assign ib_inc     = r_ib + ONE_C;

    // B wins ties: A goes only when strictly below B's head, or B is used up
    assign take_a   = (r_ia < r_cnt_a) && ((r_ib >= r_cnt_b) || cmp_lt);
    assign mrg_last = take_a ? ((ia_inc == r_cnt_a) && (r_ib == r_cnt_b))
                             : ((ib_inc == r_cnt_b) && (r_ia == r_cnt_a));
    assign mrg_load = (r_state == S_MRG_SEL) && slot_free;

    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_value       = r_value;
        n_idx         = r_idx;
        n_cnt_a       = r_cnt_a;
        n_cnt_b       = r_cnt_b;
        n_ia          = r_ia;
        n_ib          = r_ib;
        n_resp_status = r_resp_status;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        we            = 1'b0;
        waddr         = r_idx[AW-1:0];
        wdata         = r_value;
        raddr_a       = r_ia[AW-1:0];
        raddr_b       = r_ib[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_sel   = i_req.list_select;
                    n_value = i_req.value;
                    if (i_req.func == FUNC_MERGE) begin
                        if ((r_cnt_a == '0) && (r_cnt_b == '0)) begin
                            n_resp_status = ST_EMPTY;
                            n_state       = S_RESP;
                        end else begin
                            n_ia    = '0;
                            n_ib    = '0;
                            n_state = S_MRG_RD;
                        end
                    end else if (req_cnt == DEPTH_C) begin
                        n_resp_status = ST_FULL;
                        n_state       = S_RESP;
                    end else if (req_cnt == '0) begin
                        n_idx   = '0;
                        n_state = S_INS_PUT;
                    end else begin
                        // start at the tail: fetch the last entry
                        n_idx   = req_cnt;
                        raddr_a = req_cnt_m1[AW-1:0];
                        raddr_b = req_cnt_m1[AW-1:0];
                        n_state = S_INS_CMP;
                    end
                end
            end
            S_INS_CMP: begin
                raddr_a = idx_m2[AW-1:0];
                raddr_b = idx_m2[AW-1:0];
                we      = 1'b1;
                if (!cmp_lt) begin
                    // entry >= new value: move it up one place
                    wdata = ins_entry;
                    n_idx = idx_m1;
                    if (r_idx == ONE_C) begin
                        n_state = S_INS_PUT;
                    end
                end else begin
                    if (r_sel == SEL_B) begin
                        n_cnt_b = r_cnt_b + ONE_C;
                    end else begin
                        n_cnt_a = r_cnt_a + ONE_C;
                    end
                    n_resp_status = ST_INSERTED;
                    n_state       = S_RESP;
                end
            end
            S_INS_PUT: begin
                we = 1'b1;
                if (r_sel == SEL_B) begin
                    n_cnt_b = r_cnt_b + ONE_C;
                end else begin
                    n_cnt_a = r_cnt_a + ONE_C;
                end
                n_resp_status = ST_INSERTED;
                n_state       = S_RESP;
            end
            S_MRG_RD: begin
                n_state = S_MRG_SEL;
            end
            S_MRG_SEL: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = take_a ? rd_a : rd_b;
                    n_out_status = ST_MERGED;
                    n_out_last   = mrg_last;
                    if (take_a) begin
                        n_ia = ia_inc;
                    end else begin
                        n_ib = ib_inc;
                    end
                    if (mrg_last) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_ia    = '0;
                        n_ib    = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MRG_RD;
                    end
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = r_resp_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_out_valid <= n_out_valid;
        end
        r_sel         <= n_sel;
        r_value       <= n_value;
        r_idx         <= n_idx;
        r_resp_status <= n_resp_status;
        r_out_value   <= n_out_value;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    `SIM_ASSERT_NOW(a_cnt_bound, 1'b1, (r_cnt_a <= DEPTH_C) && (r_cnt_b <= DEPTH_C), "store count above depth")
    `SIM_ASSERT_NOW(a_merge_idx, 1'b1, (r_ia <= r_cnt_a) && (r_ib <= r_cnt_b), "merge index past store count")
    `SIM_ASSERT_NXT(a_merge_clear, mrg_load && mrg_last, (r_cnt_a == '0) && (r_cnt_b == '0), "stores not emptied after merge")
    `SIM_ASSERT_NXT(a_ins_grow_a, (r_state == S_INS_PUT) && (r_sel == SEL_A), r_cnt_a == $past(r_cnt_a) + ONE_C, "store A count not advanced on insert")
    `SIM_ASSERT_NXT(a_ins_grow_b, (r_state == S_INS_PUT) && (r_sel == SEL_B), r_cnt_b == $past(r_cnt_b) + ONE_C, "store B count not advanced on insert")

endmodule
